// File: src/jsee_pkg.sv
// Shared types, constants and helpers for the JSON string escape encoder.
package jsee_pkg;

  localparam int unsigned CP_W    = 21;
  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned UNIT_W  = 16;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = 1;
  localparam int unsigned QCNT_W  = 2;

  localparam logic [CP_W-1:0]   CP_BMP_MAX   = 21'h00FFFF;
  localparam logic [CP_W-1:0]   CP_SUPP_BASE = 21'h010000;
  localparam logic [CP_W-1:0]   CP_PRINT_LO  = 21'h000020;
  localparam logic [CP_W-1:0]   CP_PRINT_HI  = 21'h00007E;
  localparam logic [UNIT_W-1:0] SURR_HI_BASE = 16'hD800;
  localparam logic [UNIT_W-1:0] SURR_LO_BASE = 16'hDC00;

  localparam logic [CP_W-1:0] CP_QUOTE  = 21'h000022;
  localparam logic [CP_W-1:0] CP_BSLASH = 21'h00005C;
  localparam logic [CP_W-1:0] CP_BS     = 21'h000008;
  localparam logic [CP_W-1:0] CP_FF     = 21'h00000C;
  localparam logic [CP_W-1:0] CP_LF     = 21'h00000A;
  localparam logic [CP_W-1:0] CP_CR     = 21'h00000D;
  localparam logic [CP_W-1:0] CP_TAB    = 21'h000009;

  localparam logic [CHAR_W-1:0] CH_BSLASH = 7'h5C;
  localparam logic [CHAR_W-1:0] CH_QUOTE  = 7'h22;
  localparam logic [CHAR_W-1:0] CH_LC_B   = 7'h62;
  localparam logic [CHAR_W-1:0] CH_LC_F   = 7'h66;
  localparam logic [CHAR_W-1:0] CH_LC_N   = 7'h6E;
  localparam logic [CHAR_W-1:0] CH_LC_R   = 7'h72;
  localparam logic [CHAR_W-1:0] CH_LC_T   = 7'h74;
  localparam logic [CHAR_W-1:0] CH_LC_U   = 7'h75;
  localparam logic [CHAR_W-1:0] CH_DIGIT0 = 7'h30;
  localparam logic [CHAR_W-1:0] CH_ALPHA0 = 7'h57;  // 'a' - 10

  // Character positions inside a run
  localparam logic [IDX_W-1:0] IDX_SHORT_LAST = 4'd1;
  localparam logic [IDX_W-1:0] IDX_U1_LAST    = 4'd5;
  localparam logic [IDX_W-1:0] IDX_U2_LAST    = 4'd11;
  localparam logic [IDX_W-1:0] IDX_SECOND_ESC = 4'd6;

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_SHORT,
    KIND_U1,
    KIND_U2
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [CHAR_W-1:0]  ch;
    logic [UNIT_W-1:0]  unit_hi;
    logic [UNIT_W-1:0]  unit_lo;
  } desc_t;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
    logic [CHAR_W-1:0] ext;
    ext = {3'b000, nib};
    if (nib < 4'd10) begin
      return CH_DIGIT0 + ext;
    end else begin
      return CH_ALPHA0 + ext;
    end
  endfunction

endpackage

// File: src/jsee_front.sv
// Front end: classifies a code point into an escape descriptor.
module jsee_front
  import jsee_pkg::*;
(
  input  logic [CP_W-1:0] code_point_i,
  output desc_t           desc_o
);

  logic [CP_W-1:0] off;

  always_comb begin
    off            = code_point_i - CP_SUPP_BASE;
    desc_o.kind    = KIND_PASS;
    desc_o.ch      = code_point_i[CHAR_W-1:0];
    desc_o.unit_hi = code_point_i[UNIT_W-1:0];
    desc_o.unit_lo = SURR_LO_BASE | {6'b0, off[9:0]};
    case (code_point_i)
      CP_QUOTE: begin
        desc_o.kind = KIND_SHORT;
        desc_o.ch   = CH_QUOTE;
      end
      CP_BSLASH: begin
        desc_o.kind = KIND_SHORT;
        desc_o.ch   = CH_BSLASH;
      end
      CP_BS: begin
        desc_o.kind = KIND_SHORT;
        desc_o.ch   = CH_LC_B;
      end
      CP_FF: begin
        desc_o.kind = KIND_SHORT;
        desc_o.ch   = CH_LC_F;
      end
      CP_LF: begin
        desc_o.kind = KIND_SHORT;
        desc_o.ch   = CH_LC_N;
      end
      CP_CR: begin
        desc_o.kind = KIND_SHORT;
        desc_o.ch   = CH_LC_R;
      end
      CP_TAB: begin
        desc_o.kind = KIND_SHORT;
        desc_o.ch   = CH_LC_T;
      end
      default: begin
        if (code_point_i > CP_BMP_MAX) begin
          desc_o.kind    = KIND_U2;
          desc_o.unit_hi = SURR_HI_BASE + {5'b0, off[20:10]};
        end else if (code_point_i < CP_PRINT_LO || code_point_i > CP_PRINT_HI) begin
          desc_o.kind = KIND_U1;
        end
      end
    endcase
  end

endmodule

// File: src/jsee_fifo.sv
// Two-entry descriptor queue between front and back ends.
module jsee_fifo
  import jsee_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t push_desc_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output desc_t head_o
);

  desc_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_desc_i;
    end
  end

endmodule

// File: src/jsee_back.sv
// Back end: walks a descriptor and emits one character per cycle while the output is not stalled.
module jsee_back
  import jsee_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  desc_t             head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CHAR_W-1:0] out_char_o,
  output logic              last_of_run_o
);

  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  pos;
  logic [UNIT_W-1:0] unit;
  logic [3:0]        nib;
  logic [CHAR_W-1:0] char_d, char_q;
  logic              last_d, last_q;
  logic              valid_q, adv;

  // Position inside the current \uXXXX group
  always_comb begin
    if (idx_q >= IDX_SECOND_ESC) begin
      pos  = idx_q - IDX_SECOND_ESC;
      unit = head_i.unit_lo;
    end else begin
      pos  = idx_q;
      unit = head_i.unit_hi;
    end
    case (pos)
      4'd2:    nib = unit[15:12];
      4'd3:    nib = unit[11:8];
      4'd4:    nib = unit[7:4];
      default: nib = unit[3:0];
    endcase
  end

  always_comb begin
    char_d = CH_BSLASH;
    last_d = 1'b0;
    case (head_i.kind)
      KIND_PASS: begin
        char_d = head_i.ch;
        last_d = 1'b1;
      end
      KIND_SHORT: begin
        if (idx_q != '0) begin
          char_d = head_i.ch;
        end
        last_d = (idx_q == IDX_SHORT_LAST);
      end
      KIND_U1, KIND_U2: begin
        if (pos == 4'd0) begin
          char_d = CH_BSLASH;
        end else if (pos == 4'd1) begin
          char_d = CH_LC_U;
        end else begin
          char_d = hex_char(nib);
        end
        last_d = (head_i.kind == KIND_U1) ? (idx_q == IDX_U1_LAST)
                                          : (idx_q == IDX_U2_LAST);
      end
      default: begin
        char_d = head_i.ch;
        last_d = 1'b1;
      end
    endcase
  end

  assign adv   = !empty_i && (!valid_q || !out_stall_i);
  assign pop_o = adv && last_d;
  assign idx_d = last_d ? '0 : idx_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (adv) begin
        idx_q   <= idx_d;
        valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      char_q <= char_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o   = valid_q;
  assign out_char_o    = char_q;
  assign last_of_run_o = last_q;

endmodule

// File: src/json_string_escape_encoder.sv
// Top level of the JSON string escape encoder (ASCII-only output).
// Input channel: one code point per word on code_point_i, taken on a clock
//   edge where in_valid_i is high and in_stall_o is low.
// Output channel: one printable ASCII character per word on out_char_o,
//   last_of_run_o set on the final character of each code point's run;
//   taken on an edge where out_valid_o is high and out_stall_i is low.
// Run length: 1 char (printable ASCII), 2 (short escape), 6 (\uXXXX) or
//   12 (surrogate pair).
// With an empty queue an accepted code point is written to the descriptor
//   queue, and its first character is then registered as the output word.
// Throughput: one output character per cycle while out_stall_i is low, so
//   one code point per cycle for pass-through text; an n-character run holds
//   the back end for all n characters; its character counter sets this rate.
// A two-word descriptor queue sits between classifier and emitter, so
//   input keeps flowing while a finished character waits in the output
//   register; in_stall_o rises only when that queue is full.
// When out_stall_i is high and out_valid_o is set, the output word holds and the emitter waits.
// Reset empties the queue, clears the output valid and the back end's character counter; no other state.
module json_string_escape_encoder
  import jsee_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CP_W-1:0]   code_point_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CHAR_W-1:0] out_char_o,
  output logic              last_of_run_o
);

  desc_t front_desc, head_desc;
  logic  q_full, q_empty, q_pop;

  jsee_front u_front (
    .code_point_i (code_point_i),
    .desc_o       (front_desc)
  );

  jsee_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_desc_i (front_desc),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (head_desc)
  );

  jsee_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (q_empty),
    .head_i        (head_desc),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_char_o    (out_char_o),
    .last_of_run_o (last_of_run_o)
  );

  assign in_stall_o = q_full;

endmodule
